// ===== src/simple_machine_instruction_execute_macros.svh =====
// assertion macros for the instruction execute block
`ifndef SIMPLE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH
`define SIMPLE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH

// same-cycle implication, off while in reset
`define SMIE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define SMIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/smie_pkg.sv =====
// shared types and constants for the instruction execute block
package smie_pkg;

    localparam int NUM_REGS  = 16;
    localparam int MEM_BYTES = 256;
    localparam int RA_W      = $clog2(NUM_REGS);
    localparam int MA_W      = $clog2(MEM_BYTES);
    localparam int IN_W      = 16;
    localparam int OUT_W     = 40;

    localparam logic [3:0] OP_LOAD_MEM = 4'h1;
    localparam logic [3:0] OP_LOAD_IMM = 4'h2;
    localparam logic [3:0] OP_STORE    = 4'h3;
    localparam logic [3:0] OP_MOVE     = 4'h4;
    localparam logic [3:0] OP_ADD      = 4'h5;
    localparam logic [3:0] OP_OR       = 4'h7;
    localparam logic [3:0] OP_AND      = 4'h8;
    localparam logic [3:0] OP_XOR      = 4'h9;
    localparam logic [3:0] OP_ROTATE   = 4'hA;
    localparam logic [3:0] OP_JUMP     = 4'hB;

    typedef struct packed {
        logic [3:0] opcode;
        logic [3:0] field_r;
        logic [3:0] field_x;
        logic [3:0] field_y;
    } smie_instr_t;

    typedef struct packed {
        logic            rf_we;
        logic [RA_W-1:0] rf_waddr;
        logic [7:0]      rf_wdata;
        logic            mem_we;
        logic [MA_W-1:0] mem_waddr;
        logic [7:0]      mem_wdata;
    } smie_wb_t;

    typedef struct packed {
        logic [7:0] jump_target;
        logic       jump_taken;
        logic [7:0] mem_write_data;
        logic [7:0] mem_write_addr;
        logic       mem_write_valid;
        logic [7:0] out_value;
        logic       out_valid;
    } smie_res_t;

endpackage

// ===== src/smie_regfile.sv =====
// sixteen-entry register file with two registered read ports and write bypass
module smie_regfile (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [smie_pkg::RA_W-1:0] rd_addr_a,
    input  logic [smie_pkg::RA_W-1:0] rd_addr_b,
    output logic [7:0]               rd_data_a,
    output logic [7:0]               rd_data_b,
    output logic [7:0]               r0_data,
    input  logic                     we,
    input  logic [smie_pkg::RA_W-1:0] waddr,
    input  logic [7:0]               wdata
);
    import smie_pkg::*;

    logic [7:0]          mem_reg [NUM_REGS];
    logic [NUM_REGS-1:0] valid_reg;
    logic [7:0]          r0_reg;
    logic [7:0]          rd_a_reg;
    logic [7:0]          rd_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            r0_reg    <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
            if (waddr == '0) begin
                r0_reg <= wdata;
            end
        end
    end

    // a write in the same cycle wins over the stored entry
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (we && waddr == rd_addr_a) begin
                rd_a_reg <= wdata;
            end else begin
                rd_a_reg <= valid_reg[rd_addr_a] ? mem_reg[rd_addr_a] : '0;
            end
            if (we && waddr == rd_addr_b) begin
                rd_b_reg <= wdata;
            end else begin
                rd_b_reg <= valid_reg[rd_addr_b] ? mem_reg[rd_addr_b] : '0;
            end
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;
    assign r0_data   = r0_reg;

endmodule

// ===== src/smie_memory.sv =====
// 256-byte data memory with registered read, per-entry valid bits and write bypass
module smie_memory (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     rd_en,
    input  logic [smie_pkg::MA_W-1:0] rd_addr,
    output logic [7:0]               rd_data,
    input  logic                     we,
    input  logic [smie_pkg::MA_W-1:0] waddr,
    input  logic [7:0]               wdata
);
    import smie_pkg::*;

    logic [7:0]           mem_reg [MEM_BYTES];
    logic [MEM_BYTES-1:0] valid_reg;
    logic [7:0]           rd_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            if (we && waddr == rd_addr) begin
                rd_reg <= wdata;
            end else begin
                rd_reg <= valid_reg[rd_addr] ? mem_reg[rd_addr] : '0;
            end
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== src/smie_alu.sv =====
// instruction decode and execute: write-back and result word
module smie_alu (
    input  smie_pkg::smie_instr_t instr,
    input  logic [7:0]            opnd_a,
    input  logic [7:0]            opnd_b,
    input  logic [7:0]            mem_data,
    input  logic [7:0]            r0_data,
    output smie_pkg::smie_wb_t    wb,
    output smie_pkg::smie_res_t   res
);
    import smie_pkg::*;

    logic [7:0]  xy;
    logic [15:0] rot_wide;

    assign xy       = {instr.field_x, instr.field_y};
    assign rot_wide = {opnd_a, opnd_a} >> instr.field_y[2:0];

    always_comb begin
        wb  = '0;
        res = '0;
        wb.rf_waddr = instr.field_r;
        unique case (instr.opcode)
            OP_LOAD_MEM: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = mem_data;
            end
            OP_LOAD_IMM: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = xy;
            end
            OP_STORE: begin
                if (xy == '0) begin
                    res.out_valid = 1'b1;
                    res.out_value = opnd_a;
                end else begin
                    wb.mem_we           = 1'b1;
                    wb.mem_waddr        = xy;
                    wb.mem_wdata        = opnd_a;
                    res.mem_write_valid = 1'b1;
                    res.mem_write_addr  = xy;
                    res.mem_write_data  = opnd_a;
                end
            end
            OP_MOVE: begin
                wb.rf_we    = 1'b1;
                wb.rf_waddr = instr.field_y;
                wb.rf_wdata = opnd_a;
            end
            OP_ADD: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = opnd_a + opnd_b;
            end
            OP_OR: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = opnd_a | opnd_b;
            end
            OP_AND: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = opnd_a & opnd_b;
            end
            OP_XOR: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = opnd_a ^ opnd_b;
            end
            OP_ROTATE: begin
                wb.rf_we    = 1'b1;
                wb.rf_wdata = rot_wide[7:0];
            end
            OP_JUMP: begin
                if (r0_data == opnd_a) begin
                    res.jump_taken  = 1'b1;
                    res.jump_target = xy;
                end
            end
            default: begin
                wb.rf_we = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/simple_machine_instruction_execute.sv =====
// top level of the instruction execute block: operand read stage and result register
//
//  channel  dir  word contents (lowest bit up)
//  s_axis   in   opcode, field_r, field_x, field_y
//  m_axis   out  out_valid, out_value, mem_write_valid, mem_write_addr,
//                mem_write_data, jump_taken, jump_target, zero fill
//
// one instruction per cycle unless the output stalls; operand stage, then result register
// operands come from registered reads of the register file and memory, with
// bypass of the write made by the instruction ahead
// reset clears all registers and memory bytes at once through valid bits
// a stalled result register holds the operand stage, which then holds the input
module simple_machine_instruction_execute (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [smie_pkg::IN_W-1:0]  s_axis_tdata,  // opcode, field_r, field_x, field_y
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [smie_pkg::OUT_W-1:0] m_axis_tdata   // out_valid, out_value, mem_write_valid,
                                                      // mem_write_addr, mem_write_data,
                                                      // jump_taken, jump_target, zero fill
);
    import smie_pkg::*;

    `include "simple_machine_instruction_execute_macros.svh"

    smie_instr_t in_instr;
    smie_instr_t s1_instr_reg;
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic        m_valid_reg;
    logic        m_valid_next;
    smie_res_t   res_reg;
    smie_wb_t    wb;
    smie_res_t   res;
    logic        accept;
    logic        advance;
    logic [3:0]  rd_addr_a;
    logic [7:0]  opnd_a;
    logic [7:0]  opnd_b;
    logic [7:0]  mem_data;
    logic [7:0]  r0_data;

    assign in_instr = '{opcode:  s_axis_tdata[3:0],
                        field_r: s_axis_tdata[7:4],
                        field_x: s_axis_tdata[11:8],
                        field_y: s_axis_tdata[15:12]};

    assign advance       = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // register R for store, rotate and jump, register X otherwise
    assign rd_addr_a = (in_instr.opcode == OP_STORE || in_instr.opcode == OP_ROTATE ||
                        in_instr.opcode == OP_JUMP) ? in_instr.field_r : in_instr.field_x;

    smie_regfile u_regfile (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (in_instr.field_y),
        .rd_data_a (opnd_a),
        .rd_data_b (opnd_b),
        .r0_data   (r0_data),
        .we        (advance && wb.rf_we),
        .waddr     (wb.rf_waddr),
        .wdata     (wb.rf_wdata)
    );

    smie_memory u_memory (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr ({in_instr.field_x, in_instr.field_y}),
        .rd_data (mem_data),
        .we      (advance && wb.mem_we),
        .waddr   (wb.mem_waddr),
        .wdata   (wb.mem_wdata)
    );

    smie_alu u_alu (
        .instr    (s1_instr_reg),
        .opnd_a   (opnd_a),
        .opnd_b   (opnd_b),
        .mem_data (mem_data),
        .r0_data  (r0_data),
        .wb       (wb),
        .res      (res)
    );

    always_comb begin
        s1_valid_next = accept || (s1_valid_reg && !advance);
        m_valid_next  = advance || (m_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_instr_reg <= in_instr;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{(OUT_W - $bits(smie_res_t)){1'b0}}, res_reg};

    `SMIE_ASSERT_NOW(a_port_or_mem, m_valid_reg,
        !(res_reg.out_valid && res_reg.mem_write_valid), "port send and memory write together")
    `SMIE_ASSERT_NOW(a_mem_addr_nonzero, m_valid_reg && res_reg.mem_write_valid,
        res_reg.mem_write_addr != '0, "memory write at address zero")
    `SMIE_ASSERT_NOW(a_hold_on_stall, s1_valid_reg && m_valid_reg && !m_axis_tready,
        !s_axis_tready, "input taken while operand stage is held")
    `SMIE_ASSERT_NEXT(a_result_follows, advance, m_valid_reg, "result lost after advance")

endmodule

// ===== bench/tb_simple_machine_instruction_execute.sv =====
// self-checking bench for the instruction execute block: driver, monitor and state predictor
module tb_simple_machine_instruction_execute;
    import smie_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int N_RANDOM    = 600;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    logic [IN_W-1:0]     pending_instrs[$];
    smie_res_t           expected_results[$];
    logic [7:0]          regs[NUM_REGS];
    logic [7:0]          mem[MEM_BYTES];
    logic                in_taken = 1'b0;
    logic                out_taken = 1'b0;
    int                  send_wait = 0;
    int                  stall_wait = 0;
    bit                  send_quiet = 1'b0;
    bit                  stall_quiet = 1'b0;
    int                  mismatches = 0;
    int unsigned         cycles = 0;

    simple_machine_instruction_execute dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [IN_W-1:0] make_word(logic [3:0] op, logic [3:0] r,
                                                  logic [7:0] xy);
        return {xy[3:0], xy[7:4], r, op};
    endfunction

    function automatic int draw_wait(inout bit quiet);
        if ($urandom_range(0, 39) == 0) begin
            quiet = !quiet;
        end
        return quiet ? 0 : $urandom_range(0, 7);
    endfunction

    // applies one instruction to the register and memory copies, returns its result word
    function automatic smie_res_t execute_instr(logic [IN_W-1:0] word);
        logic [3:0]  op;
        logic [3:0]  r;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  xy;
        logic [15:0] spun;
        smie_res_t   res;
        op  = word[3:0];
        r   = word[7:4];
        x   = word[11:8];
        y   = word[15:12];
        xy  = {x, y};
        res = '0;
        case (op)
            OP_LOAD_MEM: regs[r] = mem[xy];
            OP_LOAD_IMM: regs[r] = xy;
            OP_STORE: begin
                if (xy == 8'h00) begin
                    res.out_valid = 1'b1;
                    res.out_value = regs[r];
                end else begin
                    mem[xy]             = regs[r];
                    res.mem_write_valid = 1'b1;
                    res.mem_write_addr  = xy;
                    res.mem_write_data  = regs[r];
                end
            end
            OP_MOVE: regs[y] = regs[x];
            OP_ADD:  regs[r] = regs[x] + regs[y];
            OP_OR:   regs[r] = regs[x] | regs[y];
            OP_AND:  regs[r] = regs[x] & regs[y];
            OP_XOR:  regs[r] = regs[x] ^ regs[y];
            OP_ROTATE: begin
                spun    = {regs[r], regs[r]} >> y[2:0];
                regs[r] = spun[7:0];
            end
            OP_JUMP: begin
                if (regs[0] == regs[r]) begin
                    res.jump_taken  = 1'b1;
                    res.jump_target = xy;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic logic [IN_W-1:0] random_instr();
        logic [3:0] ops[10];
        logic [3:0] op;
        logic [3:0] r;
        logic [7:0] xy;
        ops = '{OP_LOAD_MEM, OP_LOAD_IMM, OP_STORE, OP_MOVE, OP_ADD,
                OP_OR, OP_AND, OP_XOR, OP_ROTATE, OP_JUMP};
        op = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : ops[$urandom_range(0, 9)];
        r  = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3)) : 4'($urandom_range(0, 15));
        case ($urandom_range(0, 3))
            0:       xy = 8'($urandom_range(0, 7));
            1:       xy = {$urandom_range(0, 1) ? 4'hF : 4'h0, 4'($urandom_range(0, 3))};
            default: xy = 8'($urandom_range(0, 255));
        endcase
        // keep register operands in a small set now and then so results feed each other
        if (op != OP_LOAD_MEM && op != OP_LOAD_IMM && op != OP_STORE && op != OP_JUMP
            && $urandom_range(0, 1) == 0) begin
            xy = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 3))};
        end
        if (op == OP_JUMP && $urandom_range(0, 2) == 0) begin
            r = 4'h0;
        end
        return make_word(op, r, xy);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endfunction

    // input side: holds a word until taken, then idles for the drawn count
    always @(negedge aclk) begin
        if (s_axis_tvalid && !in_taken) begin
        end else if (send_wait > 0) begin
            send_wait--;
            s_axis_tvalid <= 1'b0;
        end else if (pending_instrs.size() > 0) begin
            s_axis_tdata  <= pending_instrs.pop_front();
            s_axis_tvalid <= 1'b1;
            send_wait = draw_wait(send_quiet);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // result side: back-pressure drawn per accepted word
    always @(negedge aclk) begin
        if (out_taken) begin
            stall_wait = draw_wait(stall_quiet);
        end
        if (stall_wait > 0) begin
            stall_wait--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        smie_res_t got;
        smie_res_t want;
        in_taken  <= aresetn && s_axis_tvalid && s_axis_tready;
        out_taken <= aresetn && m_axis_tvalid && m_axis_tready;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[$bits(smie_res_t)-1:0];
            if (expected_results.size() == 0) begin
                $error("result word %0h with nothing expected", m_axis_tdata);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                check_field("out_valid", want.out_valid, got.out_valid);
                check_field("out_value", want.out_value, got.out_value);
                check_field("mem_write_valid", want.mem_write_valid, got.mem_write_valid);
                check_field("mem_write_addr", want.mem_write_addr, got.mem_write_addr);
                check_field("mem_write_data", want.mem_write_data, got.mem_write_data);
                check_field("jump_taken", want.jump_taken, got.jump_taken);
                check_field("jump_target", want.jump_target, got.jump_target);
                check_field("zero fill", 0, m_axis_tdata[OUT_W-1:$bits(smie_res_t)]);
            end
        end
        if (aresetn && s_axis_tvalid && s_axis_tready) begin
            expected_results.push_back(execute_instr(s_axis_tdata));
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_simple_machine_instruction_execute: errors");
            $finish;
        end
    end

    initial begin
        foreach (regs[i]) regs[i] = '0;
        foreach (mem[i]) mem[i] = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        pending_instrs.push_back(make_word(OP_LOAD_IMM, 4'h0, 8'h00));
        pending_instrs.push_back(make_word(OP_LOAD_IMM, 4'hF, 8'hFF));
        pending_instrs.push_back(make_word(OP_LOAD_IMM, 4'h1, 8'h80));
        pending_instrs.push_back(make_word(OP_LOAD_IMM, 4'h2, 8'h7F));
        pending_instrs.push_back(make_word(OP_STORE, 4'hF, 8'hFF));
        pending_instrs.push_back(make_word(OP_STORE, 4'h1, 8'h00));
        pending_instrs.push_back(make_word(OP_LOAD_MEM, 4'h3, 8'hFF));
        pending_instrs.push_back(make_word(OP_LOAD_MEM, 4'h4, 8'h80));
        pending_instrs.push_back(make_word(OP_MOVE, 4'h0, 8'hF6));
        pending_instrs.push_back(make_word(OP_ADD, 4'h7, 8'hF1));
        pending_instrs.push_back(make_word(OP_ADD, 4'h8, 8'h11));
        pending_instrs.push_back(make_word(OP_OR, 4'h9, 8'h12));
        pending_instrs.push_back(make_word(OP_AND, 4'hA, 8'hF1));
        pending_instrs.push_back(make_word(OP_XOR, 4'hB, 8'hF2));
        pending_instrs.push_back(make_word(OP_ROTATE, 4'h2, 8'h00));
        pending_instrs.push_back(make_word(OP_ROTATE, 4'h1, 8'h03));
        pending_instrs.push_back(make_word(OP_ROTATE, 4'h2, 8'h0F));
        pending_instrs.push_back(make_word(OP_JUMP, 4'h4, 8'hFF));
        pending_instrs.push_back(make_word(OP_JUMP, 4'hF, 8'h12));
        pending_instrs.push_back(make_word(4'h0, 4'hF, 8'hFF));
        pending_instrs.push_back(make_word(4'h6, 4'h5, 8'hA5));
        pending_instrs.push_back(make_word(4'hC, 4'hA, 8'h5A));
        pending_instrs.push_back(make_word(4'hF, 4'h0, 8'h00));
        repeat (N_RANDOM) pending_instrs.push_back(random_instr());

        while (pending_instrs.size() != 0 || s_axis_tvalid) @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);
        if (mismatches == 0) begin
            $display("tb_simple_machine_instruction_execute: clean");
        end else begin
            $display("tb_simple_machine_instruction_execute: errors");
        end
        $finish;
    end

endmodule
